// ----- design/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and ring pointer helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Store geometry
    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int PTR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Fixed field widths of a transaction
    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int IN_RAW_W = CMD_W + VAL_W;
    localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = STAT_W + 3 * VAL_W + COUNT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // Output tdata bit positions
    localparam int OUT_POP_LO   = STAT_W;
    localparam int OUT_FRONT_LO = OUT_POP_LO + VAL_W;
    localparam int OUT_BACK_LO  = OUT_FRONT_LO + VAL_W;
    localparam int OUT_COUNT_LO = OUT_BACK_LO + VAL_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [WORD_BITS-1:0] word_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch incoming transaction
        logic exec;      // apply command to pointers, count and store
        logic fetch;     // load refilled end word from the store
        logic load_out;  // move result into output register
    } dq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fetch_needed;  // a pop left words behind: refill the cached end
        logic out_free;      // output register can take a result
    } dq_stat_t;

    function automatic ptr_t ring_next(input ptr_t p);
        ring_next = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic ptr_t ring_prev(input ptr_t p);
        ring_prev = (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
    endfunction

endpackage

// ----- design/dq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/dq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer: accept, execute, optional refill read, result hand-off.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t  cmd
);
    import dq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.fetch_needed ? S_FETCH : S_DONE;
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/dq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Ring pointers, count, cached front and back words, word store and output
// register of the double-ended queue.
// ----------------------------------------------------------------------------
module dq_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dq_pkg::dq_cmd_t          cmd,
    output dq_pkg::dq_stat_t         stat,
    input  logic [dq_pkg::IN_W-1:0]  in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [dq_pkg::OUT_W-1:0] out_data
);
    import dq_pkg::*;

    logic [CMD_W-1:0]  cmd_reg;
    word_t             value_reg;
    ptr_t              front_ptr_reg, front_ptr_next;
    ptr_t              back_ptr_reg,  back_ptr_next;
    cnt_t              count_reg,     count_next;
    word_t             front_word_reg, front_word_next;
    word_t             back_word_reg,  back_word_next;
    logic [STAT_W-1:0] status_reg,    status_next;
    word_t             popped_reg,    popped_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg,  out_data_next;

    logic  is_full, is_empty;
    logic  ram_we;
    ptr_t  ram_waddr, ram_raddr;
    word_t ram_rdata;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Word store
    dq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Store addressing: push writes at the new end, pop reads the word behind it
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = back_ptr_reg;
        ram_raddr = ring_next(front_ptr_reg);
        case (cmd_reg)
            CMD_PUSH_FRONT:
            begin
                ram_we    = cmd.exec && !is_full;
                ram_waddr = ring_prev(front_ptr_reg);
            end
            CMD_PUSH_BACK:
            begin
                ram_we    = cmd.exec && !is_full;
                ram_waddr = back_ptr_reg;
            end
            CMD_POP_BACK:
            begin
                ram_raddr = ring_prev(ring_prev(back_ptr_reg));
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // A pop that leaves words behind refills the cached end word
    assign stat.fetch_needed = ((cmd_reg == CMD_POP_FRONT) || (cmd_reg == CMD_POP_BACK))
                               && (count_reg > CNT_W'(1));
    assign stat.out_free     = !out_valid_reg || out_ready;

    // Command execution
    always_comb
    begin
        front_ptr_next  = front_ptr_reg;
        back_ptr_next   = back_ptr_reg;
        count_next      = count_reg;
        front_word_next = front_word_reg;
        back_word_next  = back_word_reg;
        status_next     = status_reg;
        popped_next     = popped_reg;
        if (cmd.exec)
        begin
            status_next = STAT_OK;
            popped_next = '0;
            case (cmd_reg)
                CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        front_ptr_next  = ring_prev(front_ptr_reg);
                        front_word_next = value_reg;
                        if (is_empty)
                        begin
                            back_word_next = value_reg;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        back_ptr_next  = ring_next(back_ptr_reg);
                        back_word_next = value_reg;
                        if (is_empty)
                        begin
                            front_word_next = value_reg;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        popped_next    = front_word_reg;
                        front_ptr_next = ring_next(front_ptr_reg);
                        count_next     = count_reg - 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        popped_next   = back_word_reg;
                        back_ptr_next = ring_prev(back_ptr_reg);
                        count_next    = count_reg - 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    front_ptr_next = '0;
                    back_ptr_next  = '0;
                    count_next     = '0;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
        else if (cmd.fetch)
        begin
            if (cmd_reg == CMD_POP_FRONT)
            begin
                front_word_next = ram_rdata;
            end
            else
            begin
                back_word_next = ram_rdata;
            end
        end
    end

    // Result packing; an empty queue shows zero end words
    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[STAT_W-1:0] = status_reg;
            out_data_next[OUT_POP_LO +: VAL_W] = VAL_W'(popped_reg);
            out_data_next[OUT_FRONT_LO +: VAL_W] =
                is_empty ? '0 : VAL_W'(front_word_reg);
            out_data_next[OUT_BACK_LO +: VAL_W] =
                is_empty ? '0 : VAL_W'(back_word_reg);
            out_data_next[OUT_COUNT_LO +: COUNT_W] = COUNT_W'(count_reg);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ptr_reg <= '0;
            back_ptr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_ptr_reg <= front_ptr_next;
            back_ptr_reg  <= back_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= in_data[CMD_W-1:0];
            value_reg <= WORD_BITS'(in_data[CMD_W +: VAL_W]);
        end
        front_word_reg <= front_word_next;
        back_word_reg  <= back_word_next;
        status_reg     <= status_next;
        popped_reg     <= popped_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of words in a ring store with cached front/back words.
// ----------------------------------------------------------------------------
// Sequence: a command is accepted, executed, then moved to the output register;
//   a pop that leaves words behind adds a registered store read that refills the cached end.
// The sequencer takes a new command only once the previous one is in the
//   output register.
// Reset: rst_n asynchronous, active low; clears pointers, count and the
//   output valid; store contents are left undefined and are never read.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [2:0] command, [34:3] push_value, [39:35] zero
    input  logic [dq_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [1:0] status, [33:2] popped_value, [65:34] front_value,
    // [97:66] back_value, [104:98] entry_count, [111:105] zero
    output logic [dq_pkg::OUT_W-1:0] m_axis_tdata
);
    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    dq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // Assertions
    logic [STAT_W-1:0]  out_status;
    logic [COUNT_W-1:0] out_count;
    assign out_status = m_axis_tdata[STAT_W-1:0];
    assign out_count  = m_axis_tdata[OUT_COUNT_LO +: COUNT_W];

    // One command at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted while another is in flight");

    // Count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_count <= COUNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    // Refused commands return no popped word
    a_no_pop_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_status != STAT_OK))
        |-> (m_axis_tdata[OUT_POP_LO +: VAL_W] == '0))
        else $error("popped word on refused command");

    // Empty queue shows zero end words
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_count == '0))
        |-> ((m_axis_tdata[OUT_FRONT_LO +: VAL_W] == '0)
             && (m_axis_tdata[OUT_BACK_LO +: VAL_W] == '0)))
        else $error("nonzero end word on empty queue");

    // A push is refused only when the queue is full
    a_full_status_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_status == STAT_FULL))
        |-> (out_count == COUNT_W'(CAPACITY)))
        else $error("full status with room left");

endmodule
